>>> rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked through reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/nfba_pkg.sv
// ----------------------------------------------------------------------------
// nfba_pkg
// Types and constants of the next-fit bitmap slot allocator.
// ----------------------------------------------------------------------------
package nfba_pkg;

  localparam int MAX_SLOTS  = 16384;
  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = MAX_SLOTS / WORD_BITS;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_SPARE   = 2'd3;

  localparam logic [14:0] SIZE_MAX   = 15'd16384;
  localparam logic [15:0] REJECT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_TOGGLE,
    OP_REJECT,
    OP_READ
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } back_state_t;

  typedef struct packed {
    op_t         op;
    logic [13:0] slot;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [13:0] granted_slot;
    logic        full_res;
    logic [15:0] rejected_count;
    logic [14:0] used_count;
  } result_t;

  // position of the lowest clear bit of a byte (7 when only bit 7 is clear)
  function automatic logic [2:0] lowest_zero(input logic [7:0] b);
    logic [2:0] p;
    p = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (!b[i]) p = 3'(i);
    end
    return p;
  endfunction

endpackage

>>> rtl/next_fit_bitmap_slot_allocator_top.sv
// Steps: read and reject answer when the back pops them from the queue; a release
//   in range passes READ and EVAL once; allocate passes READ and EVAL per 64-slot word.
// Items are taken one at a time: the back pops the next item only once the result
//   is popped; worst allocate scans 257 words, the start word at both ends of the wrap.
// Reset (rst, synchronous): bitmap reads as clear through per-word valid bits,
//   counters and start byte zero, slot count 16384; no clearing pass.
// ----------------------------------------------------------------------------
// next_fit_bitmap_slot_allocator_top
// Next-fit slot allocator over a bitmap with queue-style ports.
// ----------------------------------------------------------------------------
module next_fit_bitmap_slot_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [13:0] slot,
  input  logic        last,
  output logic        empty,
  input  logic        pop,
  output logic [13:0] granted_slot,
  output logic        full_res,
  output logic [15:0] rejected_count,
  output logic [14:0] used_count
);

  logic              q_valid;
  logic              q_pop;
  nfba_pkg::item_t   q_item;
  logic [14:0]       size;
  logic              out_valid;
  nfba_pkg::result_t out_res;

  nfba_front u_front (
    .clk, .rst, .cfg_wr_en, .cfg_wr_data, .push, .full, .cmd, .slot, .last,
    .size, .q_valid, .q_item, .q_pop
  );

  nfba_back u_back (
    .clk, .rst, .size, .q_valid, .q_item, .q_pop, .out_valid, .out_res,
    .out_pop (pop && out_valid)
  );

  assign empty          = !out_valid;
  assign granted_slot   = out_res.granted_slot;
  assign full_res       = out_res.full_res;
  assign rejected_count = out_res.rejected_count;
  assign used_count     = out_res.used_count;

endmodule

>>> rtl/nfba_ram.sv
// ----------------------------------------------------------------------------
// nfba_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module nfba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> rtl/nfba_front.sv
// ----------------------------------------------------------------------------
// nfba_front
// Holds the slot count, classifies input items and queues them for the back.
// ----------------------------------------------------------------------------
module nfba_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [14:0]     cfg_wr_data,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      cmd,
  input  logic [13:0]     slot,
  input  logic            last,
  output logic [14:0]     size,
  output logic            q_valid,
  output nfba_pkg::item_t q_item,
  input  logic            q_pop
);

  localparam int PW = $clog2(nfba_pkg::QUEUE_DEPTH);

  logic [14:0]     slot_count;
  nfba_pkg::item_t entries [nfba_pkg::QUEUE_DEPTH];
  nfba_pkg::item_t in_item;
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            do_push;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) slot_count <= nfba_pkg::SIZE_MAX;
    else if (cfg_wr_en) slot_count <= cfg_wr_data;
  end

  assign size = (slot_count > nfba_pkg::SIZE_MAX) ? nfba_pkg::SIZE_MAX : slot_count;

  // classify the incoming transaction
  always_comb begin
    in_item.slot = slot;
    in_item.last = last;
    unique case (cmd)
      nfba_pkg::CMD_ALLOC:   in_item.op = nfba_pkg::OP_ALLOC;
      nfba_pkg::CMD_RELEASE: in_item.op = ({1'b0, slot} >= size) ? nfba_pkg::OP_REJECT
                                                                 : nfba_pkg::OP_TOGGLE;
      default:               in_item.op = nfba_pkg::OP_READ;
    endcase
  end

  assign full    = (count == (PW+1)'(nfba_pkg::QUEUE_DEPTH));
  assign do_push = push && !full;
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= in_item;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop)   rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(do_push) - (PW+1)'(q_pop);
    end
  end

endmodule

>>> rtl/nfba_back.sv
// ----------------------------------------------------------------------------
// nfba_back
// Executes queued items against the word-organized bitmap, holds counters.
// ----------------------------------------------------------------------------
module nfba_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [14:0]       size,
  input  logic              q_valid,
  input  nfba_pkg::item_t   q_item,
  output logic              q_pop,
  output logic              out_valid,
  output nfba_pkg::result_t out_res,
  input  logic              out_pop
);

  localparam int WA = $clog2(nfba_pkg::WORD_COUNT);

  nfba_pkg::back_state_t state, state_next;
  nfba_pkg::item_t       cur;
  logic [WA-1:0]         word;
  logic                  phase2;
  logic [10:0]           start_byte;
  logic [15:0]           batch_rejects;
  logic [14:0]           set_bit_total;
  logic [nfba_pkg::WORD_COUNT-1:0] word_valid;

  logic [63:0]   ram_q;
  logic [63:0]   data;
  logic [63:0]   new_word;
  logic          ram_we;
  logic [14:0]   size_p63;
  logic [WA:0]   nw;
  logic          word_end;
  logic [WA-1:0] sw;
  logic [2:0]    sb;
  logic [2:0]    pos [8];
  logic [7:0]    ok;
  logic          hit;
  logic [2:0]    hit_b;
  logic [63:0]   tmask;
  logic          tbit;
  logic          start_ok;

  assign size_p63 = size + 15'd63;
  assign nw       = size_p63[14:6];
  assign sw       = start_byte[10:3];
  assign sb       = start_byte[2:0];
  assign word_end = ({1'b0, word} + (WA+1)'(1)) >= nw;
  assign data     = word_valid[word] ? ram_q : 64'd0;
  assign tmask    = 64'd1 << cur.slot[5:0];
  assign tbit     = data[cur.slot[5:0]];
  assign start_ok = q_valid && !out_valid;

  // per-byte search within the fetched word
  always_comb begin
    hit   = 1'b0;
    hit_b = 3'd0;
    for (int b = 0; b < 8; b++) begin
      logic in_rng;
      in_rng = 1'b1;
      if (word == sw) in_rng = phase2 ? (3'(b) < sb) : (3'(b) >= sb);
      pos[b] = nfba_pkg::lowest_zero(data[b*8 +: 8]);
      ok[b]  = (data[b*8 +: 8] != 8'hFF) && in_rng &&
               ({1'b0, word, 3'(b), pos[b]} < size);
    end
    for (int b = 7; b >= 0; b--) begin
      if (ok[b]) begin
        hit   = 1'b1;
        hit_b = 3'(b);
      end
    end
  end

  // word to write back
  always_comb begin
    if (cur.op == nfba_pkg::OP_TOGGLE) new_word = data ^ tmask;
    else new_word = data | (64'd1 << {hit_b, pos[hit_b]});
  end

  nfba_ram #(.WIDTH(64), .DEPTH(nfba_pkg::WORD_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word),
    .wdata (new_word),
    .re    (state == nfba_pkg::ST_READ),
    .raddr (word),
    .rdata (ram_q)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= nfba_pkg::ST_IDLE;
    else state <= state_next;
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    unique case (state)
      nfba_pkg::ST_IDLE: begin
        if (start_ok) begin
          q_pop = 1'b1;
          if (q_item.op == nfba_pkg::OP_TOGGLE ||
              (q_item.op == nfba_pkg::OP_ALLOC && nw != '0)) begin
            state_next = nfba_pkg::ST_READ;
          end
        end
      end
      nfba_pkg::ST_READ: state_next = nfba_pkg::ST_EVAL;
      nfba_pkg::ST_EVAL: begin
        if (cur.op == nfba_pkg::OP_TOGGLE || hit) begin
          ram_we     = 1'b1;
          state_next = nfba_pkg::ST_IDLE;
        end else if (phase2 && (word == sw || word_end)) begin
          state_next = nfba_pkg::ST_IDLE;
        end else begin
          state_next = nfba_pkg::ST_READ;
        end
      end
      default: state_next = nfba_pkg::ST_IDLE;
    endcase
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte    <= '0;
      batch_rejects <= '0;
      set_bit_total <= '0;
      word_valid    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_pop) out_valid <= 1'b0;
      unique case (state)
        nfba_pkg::ST_IDLE: begin
          if (start_ok) begin
            logic [15:0] r;
            logic        is_rej;
            logic        no_words;
            r = (batch_rejects == nfba_pkg::REJECT_MAX) ? batch_rejects
                                                        : batch_rejects + 16'd1;
            is_rej   = (q_item.op == nfba_pkg::OP_REJECT);
            no_words = (q_item.op == nfba_pkg::OP_ALLOC) && (nw == '0);
            cur    <= q_item;
            phase2 <= ({1'b0, sw} >= nw);
            if (q_item.op == nfba_pkg::OP_TOGGLE) word <= q_item.slot[13:6];
            else word <= ({1'b0, sw} >= nw) ? '0 : sw;
            out_res.granted_slot   <= '0;
            out_res.full_res       <= no_words;
            out_res.used_count     <= set_bit_total;
            out_res.rejected_count <= is_rej ? r : batch_rejects;
            if (is_rej) batch_rejects <= q_item.last ? 16'd0 : r;
            // read, reject and an allocate over a slot count of zero answer at once
            if (is_rej || no_words || q_item.op == nfba_pkg::OP_READ) out_valid <= 1'b1;
          end
        end
        nfba_pkg::ST_EVAL: begin
          if (cur.op == nfba_pkg::OP_TOGGLE) begin
            logic [14:0] t;
            t = tbit ? ((set_bit_total != '0) ? set_bit_total - 15'd1 : set_bit_total)
                     : set_bit_total + 15'd1;
            word_valid[word]   <= 1'b1;
            set_bit_total      <= t;
            out_res.used_count <= t;
            if (cur.last) batch_rejects <= '0;
            out_valid <= 1'b1;
          end else if (hit) begin
            word_valid[word]     <= 1'b1;
            start_byte           <= {word, hit_b};
            set_bit_total        <= set_bit_total + 15'd1;
            out_res.used_count   <= set_bit_total + 15'd1;
            out_res.granted_slot <= {word, hit_b, pos[hit_b]};
            out_valid <= 1'b1;
          end else if (phase2 && (word == sw || word_end)) begin
            out_res.full_res <= 1'b1;
            out_valid <= 1'b1;
          end else if (!phase2 && word_end) begin
            phase2 <= 1'b1;
            word   <= '0;
          end else begin
            word <= word + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/nfba_checker.sv
// ----------------------------------------------------------------------------
// nfba_checker
// Port-level checks of the allocator, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nfba_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [13:0] granted_slot,
  input logic        full_res,
  input logic [14:0] used_count
);

  `ASSERT_NEXT(a_rst_empty, rst, empty)
  `ASSERT_IMPL(a_full_no_grant, !empty && full_res, granted_slot == 14'd0)
  `ASSERT_IMPL(a_used_bound, !empty, used_count <= 15'd16384)
  `ASSERT_NEXT(a_hold, !rst && !empty && !pop, empty || $stable(granted_slot))

endmodule

bind next_fit_bitmap_slot_allocator_top nfba_checker u_chk (
  .clk, .rst, .empty, .pop, .granted_slot, .full_res, .used_count
);
